// ----- rtl/lcdv_pkg.sv -----
// ============================================================================
// lcdv_pkg: shared types and constants for the lattice cell moment block
// Beat formats, cell records, widths and the direction sign decoder.
// ============================================================================
package lcdv_pkg;

    // Lattice and field widths.
    localparam int NUM_DIRECTIONS = 19;
    localparam int COORD_BITS     = 8;
    localparam int DIR_W          = 5;
    localparam int VAL_W          = 24;
    localparam int DENS_W         = 29;
    localparam int MOM_W          = 30;
    localparam int VEL_W          = 24;
    localparam int FRAC_W         = 22;
    localparam int CRD_W          = 8;

    // Divider: two quotient bits per step.
    localparam int DIV_STEPS      = VEL_W / 2;
    localparam int STEP_CNT_W     = $clog2(DIV_STEPS + 1);

    // Cell queue between the accumulator and the divider.
    localparam int FIFO_DEPTH     = 2;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

    // Coordinate mask for the echoed coordinates.
    localparam logic [CRD_W-1:0] COORD_MASK = CRD_W'((64'd1 << COORD_BITS) - 64'd1);

    // Saturation limits.
    localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};
    localparam logic [MOM_W-1:0]  MOM_MAX  = {1'b0, {(MOM_W-1){1'b1}}};
    localparam logic [MOM_W-1:0]  MOM_MIN  = {1'b1, {(MOM_W-1){1'b0}}};
    localparam logic [VEL_W-1:0]  VEL_MAX  = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0]  VEL_MIN  = {1'b1, {(VEL_W-1){1'b0}}};

    // Sign codes of a lattice velocity component.
    localparam logic [1:0] SGN_ZERO  = 2'b00;
    localparam logic [1:0] SGN_PLUS  = 2'b01;
    localparam logic [1:0] SGN_MINUS = 2'b10;

    // Input beat: one distribution value.
    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic [VAL_W-1:0] dist_value;
        logic             last_of_cell;
        logic [CRD_W-1:0] cell_x;
        logic [CRD_W-1:0] cell_y;
        logic [CRD_W-1:0] cell_z;
    } t_in_beat;

    // Output beat: moments of one cell.
    typedef struct packed {
        logic [DENS_W-1:0]       density;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic                    zero_density;
        logic [CRD_W-1:0]        out_x;
        logic [CRD_W-1:0]        out_y;
        logic [CRD_W-1:0]        out_z;
    } t_out_beat;

    // Finished sums of one cell, queued for division.
    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic [MOM_W-1:0]  mom_x;
        logic [MOM_W-1:0]  mom_y;
        logic [MOM_W-1:0]  mom_z;
        logic [CRD_W-1:0]  cx;
        logic [CRD_W-1:0]  cy;
        logic [CRD_W-1:0]  cz;
    } t_cell;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

    // Sign codes of one direction on the three axes.
    typedef struct packed {
        logic [1:0] x;
        logic [1:0] y;
        logic [1:0] z;
    } t_signs;

    // Decode a D3Q19 direction into its velocity component signs.
    function automatic t_signs dir_signs(input logic [DIR_W-1:0] dir);
        t_signs s;
        unique case (dir) inside
            5'd3, 5'd7, 5'd10, 5'd13, 5'd17: s.x = SGN_PLUS;
            5'd1, 5'd5, 5'd8, 5'd11, 5'd15:  s.x = SGN_MINUS;
            default:                         s.x = SGN_ZERO;
        endcase
        unique case (dir) inside
            5'd4, 5'd11, 5'd12, 5'd13, 5'd18: s.y = SGN_PLUS;
            5'd0, 5'd5, 5'd6, 5'd7, 5'd14:    s.y = SGN_MINUS;
            default:                          s.y = SGN_ZERO;
        endcase
        unique case (dir) inside
            [5'd14:5'd18]: s.z = SGN_PLUS;
            [5'd0:5'd4]:   s.z = SGN_MINUS;
            default:       s.z = SGN_ZERO;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/lcdv_front.sv -----
// ============================================================================
// lcdv_front: distribution accumulator
// Sums density and the three momenta per beat and queues each finished cell.
// ============================================================================
module lcdv_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  lcdv_pkg::t_in_beat       i_in,
    input  lcdv_pkg::t_fifo_status   i_fifo_status,
    output logic                     o_push,
    output lcdv_pkg::t_cell          o_cell
);

    logic [lcdv_pkg::DENS_W-1:0] r_dens, n_dens;
    logic [lcdv_pkg::MOM_W-1:0]  r_mx, r_my, r_mz, n_mx, n_my, n_mz;
    logic                        w_accept;
    logic                        w_dir_ok;
    lcdv_pkg::t_signs            w_signs;
    logic [lcdv_pkg::DENS_W:0]   w_dsum;

    // Saturating signed add or subtract of one value into a momentum sum.
    function automatic logic [lcdv_pkg::MOM_W-1:0] mom_add(
        input logic [lcdv_pkg::MOM_W-1:0] acc,
        input logic [1:0]                 sgn,
        input logic [lcdv_pkg::VAL_W-1:0] val
    );
        logic [lcdv_pkg::MOM_W:0] ext;
        logic [lcdv_pkg::MOM_W:0] v;
        logic [lcdv_pkg::MOM_W:0] s;
        ext = {acc[lcdv_pkg::MOM_W-1], acc};
        v   = (lcdv_pkg::MOM_W+1)'(val);
        case (sgn)
            lcdv_pkg::SGN_PLUS:  s = ext + v;
            lcdv_pkg::SGN_MINUS: s = ext - v;
            default:             s = ext;
        endcase
        if (s[lcdv_pkg::MOM_W] != s[lcdv_pkg::MOM_W-1]) begin
            return s[lcdv_pkg::MOM_W] ? lcdv_pkg::MOM_MIN : lcdv_pkg::MOM_MAX;
        end
        return s[lcdv_pkg::MOM_W-1:0];
    endfunction

    // Stall only while the cell queue has no room.
    assign o_stall  = i_fifo_status.full;
    assign w_accept = i_valid && !o_stall;

    // Directions beyond the lattice leave the sums alone.
    assign w_dir_ok = (i_in.direction < lcdv_pkg::DIR_W'(lcdv_pkg::NUM_DIRECTIONS));
    assign w_signs  = lcdv_pkg::dir_signs(i_in.direction);
    assign w_dsum   = (lcdv_pkg::DENS_W+1)'(r_dens) + (lcdv_pkg::DENS_W+1)'(i_in.dist_value);

    // Sums including the current beat.
    always_comb begin
        n_dens = r_dens;
        n_mx   = r_mx;
        n_my   = r_my;
        n_mz   = r_mz;
        if (w_dir_ok) begin
            n_dens = w_dsum[lcdv_pkg::DENS_W] ? lcdv_pkg::DENS_MAX
                                              : w_dsum[lcdv_pkg::DENS_W-1:0];
            n_mx   = mom_add(r_mx, w_signs.x, i_in.dist_value);
            n_my   = mom_add(r_my, w_signs.y, i_in.dist_value);
            n_mz   = mom_add(r_mz, w_signs.z, i_in.dist_value);
        end
    end

    // Accumulators restart from zero after each cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dens <= '0;
            r_mx   <= '0;
            r_my   <= '0;
            r_mz   <= '0;
        end else if (w_accept) begin
            if (i_in.last_of_cell) begin
                r_dens <= '0;
                r_mx   <= '0;
                r_my   <= '0;
                r_mz   <= '0;
            end else begin
                r_dens <= n_dens;
                r_mx   <= n_mx;
                r_my   <= n_my;
                r_mz   <= n_mz;
            end
        end
    end

    // The last beat of a cell hands its finished sums to the queue.
    assign o_push        = w_accept && i_in.last_of_cell;
    assign o_cell.density = n_dens;
    assign o_cell.mom_x  = n_mx;
    assign o_cell.mom_y  = n_my;
    assign o_cell.mom_z  = n_mz;
    assign o_cell.cx     = i_in.cell_x & lcdv_pkg::COORD_MASK;
    assign o_cell.cy     = i_in.cell_y & lcdv_pkg::COORD_MASK;
    assign o_cell.cz     = i_in.cell_z & lcdv_pkg::COORD_MASK;

endmodule

// ----- rtl/lcdv_fifo.sv -----
// ============================================================================
// lcdv_fifo: cell queue
// Short queue of finished cell sums between the accumulator and the divider.
// ============================================================================
module lcdv_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lcdv_pkg::t_cell        i_cell,
    input  logic                   i_pop,
    output lcdv_pkg::t_cell        o_cell,
    output lcdv_pkg::t_fifo_status o_status
);

    lcdv_pkg::t_cell             r_mem [lcdv_pkg::FIFO_DEPTH];
    logic [lcdv_pkg::PTR_W-1:0]  r_wr, r_rd;
    logic [lcdv_pkg::CNT_W-1:0]  r_cnt;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cell;
        end
    end

    assign o_cell         = r_mem[r_rd];
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == lcdv_pkg::CNT_W'(lcdv_pkg::FIFO_DEPTH));

endmodule

// ----- rtl/lcdv_div.sv -----
// ============================================================================
// lcdv_div: velocity divider
// Restoring division of momentum by density, two quotient bits per step.
// ============================================================================
module lcdv_div (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_step,
    input  logic [lcdv_pkg::MOM_W-1:0]        i_mom,
    input  logic [lcdv_pkg::DENS_W-1:0]       i_dens,
    output logic signed [lcdv_pkg::VEL_W-1:0] o_vel
);

    logic [lcdv_pkg::DENS_W-1:0] r_dens;
    logic [lcdv_pkg::DENS_W-1:0] r_rem, n_rem;
    logic [lcdv_pkg::VEL_W-1:0]  r_bits;
    logic [lcdv_pkg::VEL_W-1:0]  r_quo;
    logic                        r_neg;
    logic                        r_ovf;
    logic [1:0]                  n_qbits;
    logic                        w_neg;
    logic [lcdv_pkg::MOM_W-1:0]  w_mag;
    logic                        w_ovf;
    logic [lcdv_pkg::DENS_W:0]   w_t1, w_s1, w_t2, w_s2, w_dext;
    logic                        w_sat;

    // Magnitude, and a quotient that would not fit in the velocity bits.
    assign w_neg = i_mom[lcdv_pkg::MOM_W-1];
    assign w_mag = w_neg ? (~i_mom + 1'b1) : i_mom;
    assign w_ovf = ({1'b0, w_mag} >= {i_dens, 2'b00});

    // Two compare-and-subtract steps of the long division.
    assign w_dext  = {1'b0, r_dens};
    assign w_t1    = {r_rem, r_bits[lcdv_pkg::VEL_W-1]};
    assign n_qbits[1] = (w_t1 >= w_dext);
    assign w_s1    = n_qbits[1] ? (w_t1 - w_dext) : w_t1;
    assign w_t2    = {w_s1[lcdv_pkg::DENS_W-1:0], r_bits[lcdv_pkg::VEL_W-2]};
    assign n_qbits[0] = (w_t2 >= w_dext);
    assign w_s2    = n_qbits[0] ? (w_t2 - w_dext) : w_t2;
    assign n_rem   = w_s2[lcdv_pkg::DENS_W-1:0];

    // Load a new division or advance the current one.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dens <= i_dens;
            r_neg  <= w_neg;
            r_ovf  <= w_ovf;
            r_rem  <= lcdv_pkg::DENS_W'(w_mag >> 2);
            r_bits <= {w_mag[1:0], {lcdv_pkg::FRAC_W{1'b0}}};
            r_quo  <= '0;
        end else if (i_step) begin
            r_rem  <= n_rem;
            r_bits <= {r_bits[lcdv_pkg::VEL_W-3:0], 2'b00};
            r_quo  <= {r_quo[lcdv_pkg::VEL_W-3:0], n_qbits};
        end
    end

    // Sign and saturation; a magnitude of 2^23 saturates either way.
    assign w_sat = r_ovf || r_quo[lcdv_pkg::VEL_W-1];
    always_comb begin
        if (r_neg) begin
            o_vel = w_sat ? lcdv_pkg::VEL_MIN : (~r_quo + 1'b1);
        end else begin
            o_vel = w_sat ? lcdv_pkg::VEL_MAX : r_quo;
        end
    end

endmodule

// ----- rtl/lcdv_back.sv -----
// ============================================================================
// lcdv_back: velocity stage
// Pops finished cells, divides the three momenta and holds the output beat.
// ============================================================================
module lcdv_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lcdv_pkg::t_cell        i_cell,
    input  lcdv_pkg::t_fifo_status i_fifo_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output lcdv_pkg::t_out_beat    o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [lcdv_pkg::STEP_CNT_W-1:0] r_cnt;
    logic                            r_valid;
    lcdv_pkg::t_out_beat             r_out;
    logic [lcdv_pkg::DENS_W-1:0]     r_dens;
    logic [lcdv_pkg::CRD_W-1:0]      r_cx, r_cy, r_cz;
    logic                            w_step;
    logic                            w_out_load;
    logic signed [lcdv_pkg::VEL_W-1:0] w_vx, w_vy, w_vz;
    logic                            w_zero;

    assign o_pop      = (r_state == S_IDLE) && !i_fifo_status.empty;
    assign w_step     = (r_state == S_DIV);
    assign w_out_load = (r_state == S_FIN) && (!r_valid || !i_stall);

    // One divider per axis, stepped together.
    lcdv_div u_div_x (
        .i_clk  (i_clk),
        .i_load (o_pop),
        .i_step (w_step),
        .i_mom  (i_cell.mom_x),
        .i_dens (i_cell.density),
        .o_vel  (w_vx)
    );

    lcdv_div u_div_y (
        .i_clk  (i_clk),
        .i_load (o_pop),
        .i_step (w_step),
        .i_mom  (i_cell.mom_y),
        .i_dens (i_cell.density),
        .o_vel  (w_vy)
    );

    lcdv_div u_div_z (
        .i_clk  (i_clk),
        .i_load (o_pop),
        .i_step (w_step),
        .i_mom  (i_cell.mom_z),
        .i_dens (i_cell.density),
        .o_vel  (w_vz)
    );

    // Sequencer over the division steps.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == lcdv_pkg::STEP_CNT_W'(lcdv_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt <= '0;
            end else if (w_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Cell fields that bypass the dividers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dens <= i_cell.density;
            r_cx   <= i_cell.cx;
            r_cy   <= i_cell.cy;
            r_cz   <= i_cell.cz;
        end
    end

    // Output register; a zero density forces zero velocities.
    assign w_zero = (r_dens == '0);
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.density      <= r_dens;
            r_out.vel_x        <= w_zero ? '0 : w_vx;
            r_out.vel_y        <= w_zero ? '0 : w_vy;
            r_out.vel_z        <= w_zero ? '0 : w_vz;
            r_out.zero_density <= w_zero;
            r_out.out_x        <= r_cx;
            r_out.out_y        <= r_cy;
            r_out.out_z        <= r_cz;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// ----- rtl/lattice_cell_density_velocity_top.sv -----
// ============================================================================
// lattice_cell_density_velocity_top: D3Q19 cell density and velocity
// Accumulates the 19 distributions of a cell and emits its four moments.
// ============================================================================
// Usage:
//   The input channel takes one distribution value per beat (valid/stall).
//   The beat marked last_of_cell closes the cell and carries its coordinates.
//   The input side accepts one beat per cycle; it stalls only while both
//   entries of the two-deep cell queue are occupied.
//   Each closed cell is divided in order: a load, twelve steps of
//   two quotient bits in three parallel dividers, then a fill of the
//   output register. A result beat follows its last input beat through
//   the queue, the dividers and the output register, and a 19-beat cell
//   stream runs at one beat per cycle without input stalls while the
//   receiver does not stall. Cells whose last beats come closer together
//   than the divider sequence lasts are limited by it and fill the queue.
//   The output register holds a result while the receiver stalls; the
//   input side keeps accumulating until the queue is full.
//   Synchronous reset clears the sums, the queue and the output valid.
// ============================================================================
module lattice_cell_density_velocity_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lcdv_pkg::t_in_beat   i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lcdv_pkg::t_out_beat  o_out
);

    lcdv_pkg::t_fifo_status w_fifo_status;
    lcdv_pkg::t_cell        w_push_cell;
    lcdv_pkg::t_cell        w_pop_cell;
    logic                   w_push;
    logic                   w_pop;

    // Accumulator front end.
    lcdv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in          (i_in),
        .i_fifo_status (w_fifo_status),
        .o_push        (w_push),
        .o_cell        (w_push_cell)
    );

    // Cell queue.
    lcdv_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cell   (w_push_cell),
        .i_pop    (w_pop),
        .o_cell   (w_pop_cell),
        .o_status (w_fifo_status)
    );

    // Divider back end.
    lcdv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell        (w_pop_cell),
        .i_fifo_status (w_fifo_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out         (o_out)
    );

    // The back end never pops an empty queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_status.empty)
        else $error("cell queue popped while empty");

    // A full queue still holds a cell in the next cycle.
    a_full_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_status.full |=> !w_fifo_status.empty)
        else $error("cell queue lost entries");

    // A zero density result carries zero velocities.
    a_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.zero_density) |->
            (o_out.vel_x == '0 && o_out.vel_y == '0 && o_out.vel_z == '0))
        else $error("nonzero velocity with zero density");

    // The zero flag matches the density field.
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.zero_density == (o_out.density == '0)))
        else $error("zero density flag mismatch");

endmodule
